@@ hw/rtl/three_tier_sliding_window_limiter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the three-tier sliding window limiter
// Concurrent checks sampled on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef THREE_TIER_SLIDING_WINDOW_LIMITER_ASSERT_SVH
`define THREE_TIER_SLIDING_WINDOW_LIMITER_ASSERT_SVH

// Same-cycle implication.
`define TSWL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSWL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/tswl_pkg.sv @@
// ----------------------------------------------------------------------------
// tswl_pkg
// Shared widths, register map and reset values for the sliding window limiter.
// ----------------------------------------------------------------------------
package tswl_pkg;

	localparam int STAMP_W    = 32;
	localparam int WINDOW_W   = 32;
	localparam int LIMIT_W    = 6;
	localparam int TOTAL_W    = 32;
	localparam int TIER_N     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int HISTORY_DEPTH_DEF = 64;
	localparam int TIME_BITS_DEF     = 32;

	// tier positions in tier_hits
	localparam int TIER_SHORT = 0;
	localparam int TIER_MID   = 1;
	localparam int TIER_LONG  = 2;

	localparam logic [LIMIT_W-1:0]  SHORT_LIMIT_RST  = LIMIT_W'(3);
	localparam logic [WINDOW_W-1:0] SHORT_WINDOW_RST = WINDOW_W'(1);
	localparam logic [LIMIT_W-1:0]  MID_LIMIT_RST    = LIMIT_W'(20);
	localparam logic [WINDOW_W-1:0] MID_WINDOW_RST   = WINDOW_W'(10);
	localparam logic [LIMIT_W-1:0]  LONG_LIMIT_RST   = LIMIT_W'(60);
	localparam logic [WINDOW_W-1:0] LONG_WINDOW_RST  = WINDOW_W'(60);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_LIMIT  = 3'd0,
		REG_SHORT_WINDOW = 3'd1,
		REG_MID_LIMIT    = 3'd2,
		REG_MID_WINDOW   = 3'd3,
		REG_LONG_LIMIT   = 3'd4,
		REG_LONG_WINDOW  = 3'd5
	} cfg_reg_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

@@ hw/rtl/three_tier_sliding_window_limiter.sv @@
// ----------------------------------------------------------------------------
// three_tier_sliding_window_limiter
// Sliding-window request limiter with three configurable tiers.
// ----------------------------------------------------------------------------
// Each input transaction carries the timestamp of one request; timestamps must
// never decrease. The block keeps the newest HISTORY_DEPTH timestamps and, for
// each tier, looks at the request that lies "limit" places back. If that
// request exists and its time plus the tier window is greater than the current
// time, more than "limit" requests fall inside (now - window, now] and the tier
// is hit. Every request yields one result transaction: the three tier hits, a
// violation flag, and a saturating running count of violating requests.
// Throughput is one transaction per cycle while the output is not stalled; the
// result passes through three register stages (history read, window compare,
// result register). The history memory is kept as three copies, one
// per tier, so each copy serves a single read address per cycle; a tier with
// limit zero compares against the current request itself. Stages with no
// transaction absorb output stalls, so inputs keep flowing until all three
// stages hold work. Configuration registers are written through cfg_wr_en /
// cfg_index / cfg_data and must only change while no transaction is in flight;
// unknown indexes are ignored.
// ----------------------------------------------------------------------------
`include "three_tier_sliding_window_limiter_assert.svh"

module three_tier_sliding_window_limiter #(
	parameter int HISTORY_DEPTH = tswl_pkg::HISTORY_DEPTH_DEF,
	parameter int TIME_BITS     = tswl_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_wr_en,
	input  logic [tswl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tswl_pkg::CFG_DATA_W-1:0] cfg_data,
	// request input
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tswl_pkg::STAMP_W-1:0]    stamp,
	// result output
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            violates,
	output logic [tswl_pkg::TIER_N-1:0]     tier_hits,
	output logic [tswl_pkg::TOTAL_W-1:0]    violation_total
);
	import tswl_pkg::*;

	localparam int IDX_W  = $clog2(HISTORY_DEPTH);
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int LF_W   = max_int(FILL_W, LIMIT_W);
	localparam int EXT_W  = max_int(TIME_BITS, STAMP_W);

	// configuration
	logic [LIMIT_W-1:0]  limit_q  [TIER_N];
	logic [WINDOW_W-1:0] window_q [TIER_N];

	// history bookkeeping
	logic [IDX_W-1:0]  head_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_nx;

	// pipeline control
	logic accept;
	logic adv1;
	logic adv2;
	logic load2;
	logic out_load;
	logic v1_q;
	logic v2_q;
	logic out_valid_q;

	// stage payload
	logic [EXT_W-1:0]     stamp_ext;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] stamp_s1;
	logic [TIER_N-1:0]    tier_ok_s1;
	logic [TIER_N-1:0]    fwd_s1;
	logic [TIER_N-1:0]    tier_ok;
	logic [TIER_N-1:0]    fwd;
	logic [IDX_W-1:0]     rd_addr [TIER_N];
	logic [TIME_BITS-1:0] rd_data [TIER_N];
	logic [TIME_BITS-1:0] entry   [TIER_N];
	logic [TIER_N-1:0]    hits;
	logic [TIER_N-1:0]    hits_s2;

	// result
	logic [TIER_N-1:0]  tier_hits_q;
	logic [TOTAL_W-1:0] violation_count_q;
	logic [TOTAL_W-1:0] count_nx;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q[TIER_SHORT]  <= SHORT_LIMIT_RST;
			window_q[TIER_SHORT] <= SHORT_WINDOW_RST;
			limit_q[TIER_MID]    <= MID_LIMIT_RST;
			window_q[TIER_MID]   <= MID_WINDOW_RST;
			limit_q[TIER_LONG]   <= LONG_LIMIT_RST;
			window_q[TIER_LONG]  <= LONG_WINDOW_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SHORT_LIMIT:  limit_q[TIER_SHORT]  <= cfg_data[LIMIT_W-1:0];
				REG_SHORT_WINDOW: window_q[TIER_SHORT] <= cfg_data[WINDOW_W-1:0];
				REG_MID_LIMIT:    limit_q[TIER_MID]    <= cfg_data[LIMIT_W-1:0];
				REG_MID_WINDOW:   window_q[TIER_MID]   <= cfg_data[WINDOW_W-1:0];
				REG_LONG_LIMIT:   limit_q[TIER_LONG]   <= cfg_data[LIMIT_W-1:0];
				REG_LONG_WINDOW:  window_q[TIER_LONG]  <= cfg_data[WINDOW_W-1:0];
				default: ;  // drop writes to unmapped indexes
			endcase
		end
	end

	// ------------------------------------------------------- flow control
	// Each stage advances when the one after it is empty or moving on.
	assign adv2     = !out_valid_q || out_ready;
	assign out_load = v2_q && adv2;
	assign adv1     = !v2_q || adv2;
	assign load2    = v1_q && adv1;
	assign in_ready = !v1_q || adv1;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v1_q <= accept;
			end
			if (adv1) begin
				v2_q <= v1_q;
			end
			if (adv2) begin
				out_valid_q <= v2_q;
			end
		end
	end

	// ------------------------------------------------------- history ring
	// Keep only the low TIME_BITS of the stamp.
	assign stamp_ext = EXT_W'(stamp);
	assign now       = stamp_ext[TIME_BITS-1:0];

	// fill as it stands once the current request is stored
	assign fill_nx = (fill_q != FILL_W'(HISTORY_DEPTH)) ? fill_q + 1'b1 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			head_q <= (head_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
			fill_q <= fill_nx;
		end
	end

	// ---------------------------------------------- per-tier read and test
	for (genvar k = 0; k < TIER_N; k++) begin : g_tier
		logic [LF_W-1:0] lim_ext;
		logic [LF_W-1:0] head_ext;
		logic [LF_W-1:0] back;

		// Step back "limit" slots from the current slot, wrapping at the depth.
		always_comb begin
			lim_ext  = LF_W'(limit_q[k]);
			head_ext = LF_W'(head_q);
			tier_ok[k] = lim_ext < LF_W'(fill_nx);
			fwd[k]     = (limit_q[k] == '0);
			if (head_ext >= lim_ext) begin
				back = head_ext - lim_ext;
			end else begin
				back = LF_W'(HISTORY_DEPTH) - lim_ext + head_ext;
			end
			rd_addr[k] = tier_ok[k] ? back[IDX_W-1:0] : '0;
		end

		tswl_hist_ram #(
			.DEPTH (HISTORY_DEPTH),
			.WIDTH (TIME_BITS)
		) u_ram (
			.clk     (clk),
			.wr_en   (accept),
			.wr_addr (head_q),
			.wr_data (now),
			.rd_en   (accept),
			.rd_addr (rd_addr[k]),
			.rd_data (rd_data[k])
		);

		// limit zero points at the request itself, which the memory has not
		// delivered yet: take it from the stage register instead
		assign entry[k] = fwd_s1[k] ? stamp_s1 : rd_data[k];

		tswl_tier_check #(
			.TIME_BITS (TIME_BITS)
		) u_check (
			.entry_ok (tier_ok_s1[k]),
			.entry    (entry[k]),
			.now      (stamp_s1),
			.window   (window_q[k]),
			.hit      (hits[k])
		);
	end

	// stage 1 payload travels alongside the memory read
	always_ff @(posedge clk) begin
		if (accept) begin
			stamp_s1   <= now;
			tier_ok_s1 <= tier_ok;
			fwd_s1     <= fwd;
		end
	end

	// stage 2 holds the tier verdicts
	always_ff @(posedge clk) begin
		if (load2) begin
			hits_s2 <= hits;
		end
	end

	// ------------------------------------------------------------ result
	// Advance the violation count only when a result is loaded; hold at max.
	assign count_nx = ((hits_s2 != '0) && (violation_count_q != '1)) ?
		violation_count_q + 1'b1 : violation_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			violation_count_q <= '0;
		end else if (out_load) begin
			violation_count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			tier_hits_q <= hits_s2;
		end
	end

	assign out_valid       = out_valid_q;
	assign tier_hits       = tier_hits_q;
	assign violates        = |tier_hits_q;
	assign violation_total = violation_count_q;

	// -------------------------------------------------------- assertions
	`TSWL_ASSERT_NOW(a_head_tracks_fill, fill_q != FILL_W'(HISTORY_DEPTH), FILL_W'(head_q) == fill_q, "history head and fill count disagree before the ring is full")
	`TSWL_ASSERT_NEXT(a_count_only_on_hit, !(out_load && (hits_s2 != '0)), $stable(violation_count_q), "violation count moved without a violating result")
	`TSWL_ASSERT_NEXT(a_count_saturates, violation_count_q == '1, violation_count_q == '1, "violation count wrapped past its maximum")

endmodule

@@ hw/rtl/tswl_hist_ram.sv @@
// ----------------------------------------------------------------------------
// tswl_hist_ram
// Timestamp history memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tswl_hist_ram #(
	parameter int DEPTH = tswl_pkg::HISTORY_DEPTH_DEF,
	parameter int WIDTH = tswl_pkg::TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	import tswl_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

@@ hw/rtl/tswl_tier_check.sv @@
// ----------------------------------------------------------------------------
// tswl_tier_check
// One tier's window test: older entry plus window lies beyond the current time.
// ----------------------------------------------------------------------------
module tswl_tier_check #(
	parameter int TIME_BITS = tswl_pkg::TIME_BITS_DEF
) (
	input  logic                          entry_ok,
	input  logic [TIME_BITS-1:0]          entry,
	input  logic [TIME_BITS-1:0]          now,
	input  logic [tswl_pkg::WINDOW_W-1:0] window,
	output logic                          hit
);
	import tswl_pkg::*;

	// one bit above the wider operand so the sum never wraps
	localparam int CMP_W = max_int(TIME_BITS, WINDOW_W) + 1;

	logic [CMP_W-1:0] reach;

	assign reach = CMP_W'(entry) + CMP_W'(window);
	assign hit   = entry_ok && (reach > CMP_W'(now));

endmodule
